### sv/region_stats_adjacency_unit_macros.svh
// ----------------------------------------------------------------------------
// Region stats adjacency unit - assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef REGION_STATS_ADJACENCY_UNIT_MACROS_SVH
`define REGION_STATS_ADJACENCY_UNIT_MACROS_SVH

// same-cycle implication
`define RSA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rsa check failed");

// next-cycle implication
`define RSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rsa check failed");

`endif

### sv/rsa_pkg.sv
// ----------------------------------------------------------------------------
// rsa_pkg
// Types and constants for the region stats adjacency unit.
// ----------------------------------------------------------------------------
package rsa_pkg;

    localparam int LABEL_W     = 10;
    localparam int REGIONS     = 1 << LABEL_W;
    localparam int COORD_W     = 12;
    localparam int LINE_DEPTH  = 1 << COORD_W;
    localparam int DIM_W       = 13;
    localparam int RCNT_W      = 11;
    localparam int CNT_W       = 25;
    localparam int SUM_W       = 32;
    localparam int ADJ_BITS    = 64;
    localparam int ADJ_SEL_W   = 6;
    localparam int ADJ_AW      = 2 * LABEL_W - ADJ_SEL_W;
    localparam int ADJ_WORDS   = 1 << ADJ_AW;
    localparam int MAX_NB      = 10;
    localparam int NB_W        = 4;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 120;

    localparam logic [CNT_W-1:0] COUNT_CAP  = 25'd16777216;
    localparam logic [DIM_W-1:0] DIM_MAX    = 13'd4096;
    localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd960;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd540;
    localparam logic [RCNT_W-1:0] RCNT_RST  = 11'd1000;
    localparam logic [RCNT_W-1:0] RCNT_MAX  = 11'd1024;

    typedef enum logic [1:0] {
        ACT_PIXEL = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } rsa_action_t;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_RCOUNT = 2'd2,
        REG_SPARE  = 2'd3
    } rsa_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_UPD,
        ST_ADJ_RD,
        ST_ADJ_WR,
        ST_Q_STAT,
        ST_Q_DIV,
        ST_Q_RDW,
        ST_Q_SCAN,
        ST_Q_FIN
    } rsa_state_t;

    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [SUM_W-1:0]   rsum;
        logic [SUM_W-1:0]   gsum;
        logic [SUM_W-1:0]   bsum;
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] max_y;
    } rsa_stats_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [7:0] v);
        logic [SUM_W:0] t;
        t = {1'b0, s} + {{(SUM_W-7){1'b0}}, v};
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

endpackage

### sv/region_stats_adjacency_unit.sv
// ----------------------------------------------------------------------------
// region_stats_adjacency_unit
// Per-label pixel statistics, bounding boxes and label adjacency over a
// raster pixel stream, with region queries listing up to ten neighbors.
// ----------------------------------------------------------------------------
//  channel  | direction | content
//  s_*      | in        | tuser: action; tdata: label, red, green, blue
//  m_*      | out       | tuser: neighbor_valid; tdata: region stats, neighbor_id
//  cfg_*    | in        | register index, write data
//
//  Pixel beat: stats update, plus a read-modify-write of the 64-bit adjacency
//  memory word per adjacency bit set (up to four per pixel).
//  Query beat: serial divider (32 steps per color), then a neighbor scan of one
//  bit per cycle while the output is not stalled, one word read per 64 labels.
//  Reset and clear beats run a clearing pass over the stats and adjacency
//  memories; no beat is taken meanwhile. A stalled output holds the neighbor scan.
// ----------------------------------------------------------------------------
module region_stats_adjacency_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rsa_pkg::IN_DATA_W-1:0]  s_tdata,   // label, red, green, blue
    input  logic [1:0]                    s_tuser,   // action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rsa_pkg::OUT_DATA_W-1:0] m_tdata,  // region, pixel_count, mean_red,
                                                     // mean_green, mean_blue, min_x,
                                                     // max_x, min_y, max_y, neighbor_id
    output logic                          m_tuser,   // neighbor_valid
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [rsa_pkg::DIM_W-1:0]      cfg_data
);
    import rsa_pkg::*;

    rsa_state_t state_reg, state_next;

    logic [DIM_W-1:0]   width_reg, height_reg;
    logic [RCNT_W-1:0]  rcount_reg;
    logic [COORD_W-1:0] x_reg, y_reg;
    logic [LABEL_W-1:0] left_reg, lab_reg, left_save_reg, above_reg;
    logic [7:0]         red_reg, green_reg, blue_reg;
    logic [ADJ_AW-1:0]  clr_reg;
    logic [3:0]         op_mask_reg;

    logic [1:0]         div_sel_reg;
    logic [4:0]         div_step_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [SUM_W-1:0]   quo_reg, dvd_reg;
    logic [7:0]         mean_reg [3];

    logic [RCNT_W-1:0]  scan_reg;
    logic [NB_W-1:0]    found_reg;
    logic [LABEL_W-1:0] pend_reg;
    logic               pend_vld_reg;

    logic                  m_tvalid_reg, m_tuser_reg, m_tlast_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // memories
    logic [LABEL_W-1:0]  line_mem [LINE_DEPTH];
    rsa_stats_t          stat_mem [REGIONS];
    logic [ADJ_BITS-1:0] adj_mem  [ADJ_WORDS];

    logic [LABEL_W-1:0]  line_rd_reg;
    rsa_stats_t          stat_rd_reg;
    logic [ADJ_BITS-1:0] adj_rd_reg;

    logic                stat_re, stat_we, line_re, line_we, adj_re, adj_we;
    logic [LABEL_W-1:0]  stat_raddr, stat_waddr;
    rsa_stats_t          stat_wdata;
    logic [ADJ_AW-1:0]   adj_raddr, adj_waddr;
    logic [ADJ_BITS-1:0] adj_wdata;

    logic               acc, slot_free;
    logic [DIM_W-1:0]   w_eff, h_eff, x1, y1;
    logic [RCNT_W-1:0]  lim;
    logic               hv, vv;
    rsa_stats_t         upd;
    logic [1:0]         op_idx;
    logic [LABEL_W-1:0] op_a, op_b;
    logic [CNT_W:0]     rem_s;
    logic               ge;
    logic [SUM_W-1:0]   quo_fin;
    logic [7:0]         mean_fin;
    logic               scan_end, hit, emit, emit_nv, emit_last;
    logic [LABEL_W-1:0] emit_id;
    logic               cnt_nz;

    assign acc       = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;

    always_comb begin
        w_eff = (width_reg == '0) ? DIM_W'(1) : ((width_reg > DIM_MAX) ? DIM_MAX : width_reg);
        h_eff = (height_reg == '0) ? DIM_W'(1) :
                ((height_reg > DIM_MAX) ? DIM_MAX : height_reg);
        lim   = (rcount_reg > RCNT_MAX) ? RCNT_MAX : rcount_reg;
        x1    = {1'b0, x_reg} + DIM_W'(1);
        y1    = {1'b0, y_reg} + DIM_W'(1);
        hv    = (x_reg != '0) && (y1 < h_eff) && (left_reg != lab_reg);
        vv    = (y_reg != '0) && (x1 < w_eff) && (line_rd_reg != lab_reg);
    end

    // pixel statistics update
    always_comb begin
        upd = stat_rd_reg;
        if (stat_rd_reg.count == '0) begin
            upd.min_x = x_reg;
            upd.max_x = x_reg;
            upd.min_y = y_reg;
            upd.max_y = y_reg;
        end else begin
            if (x_reg < stat_rd_reg.min_x) upd.min_x = x_reg;
            if (x_reg > stat_rd_reg.max_x) upd.max_x = x_reg;
            if (y_reg < stat_rd_reg.min_y) upd.min_y = y_reg;
            if (y_reg > stat_rd_reg.max_y) upd.max_y = y_reg;
        end
        if (stat_rd_reg.count < COUNT_CAP) upd.count = stat_rd_reg.count + CNT_W'(1);
        upd.rsum = sat_add(stat_rd_reg.rsum, red_reg);
        upd.gsum = sat_add(stat_rd_reg.gsum, green_reg);
        upd.bsum = sat_add(stat_rd_reg.bsum, blue_reg);
    end

    // adjacency op select
    always_comb begin
        priority if (op_mask_reg[0]) op_idx = 2'd0;
        else if (op_mask_reg[1])     op_idx = 2'd1;
        else if (op_mask_reg[2])     op_idx = 2'd2;
        else                         op_idx = 2'd3;
        unique case (op_idx)
            2'd0: begin op_a = left_save_reg; op_b = lab_reg; end
            2'd1: begin op_a = lab_reg; op_b = left_save_reg; end
            2'd2: begin op_a = above_reg; op_b = lab_reg; end
            default: begin op_a = lab_reg; op_b = above_reg; end
        endcase
    end

    // divider step
    always_comb begin
        rem_s    = {rem_reg, dvd_reg[SUM_W-1]};
        ge       = rem_s >= {1'b0, stat_rd_reg.count};
        quo_fin  = {quo_reg[SUM_W-2:0], ge};
        mean_fin = (|quo_fin[SUM_W-1:8]) ? 8'hFF : quo_fin[7:0];
    end

    // neighbor scan
    always_comb begin
        scan_end = (scan_reg >= lim) || (found_reg == NB_W'(MAX_NB));
        hit      = adj_rd_reg[scan_reg[ADJ_SEL_W-1:0]] && (scan_reg[LABEL_W-1:0] != lab_reg);
        emit      = 1'b0;
        emit_id   = pend_reg;
        emit_nv   = 1'b1;
        emit_last = 1'b0;
        if (state_reg == ST_Q_SCAN && !scan_end && hit && pend_vld_reg && slot_free) begin
            emit = 1'b1;
        end
        if (state_reg == ST_Q_FIN && slot_free) begin
            emit      = 1'b1;
            emit_nv   = pend_vld_reg;
            emit_id   = pend_vld_reg ? pend_reg : '0;
            emit_last = 1'b1;
        end
    end

    // memory port control
    always_comb begin
        stat_re    = 1'b0;
        stat_we    = 1'b0;
        stat_raddr = s_tdata[LABEL_W-1:0];
        stat_waddr = lab_reg;
        stat_wdata = upd;
        line_re    = 1'b0;
        line_we    = 1'b0;
        adj_re     = 1'b0;
        adj_we     = 1'b0;
        adj_raddr  = {op_a, op_b[LABEL_W-1:ADJ_SEL_W]};
        adj_waddr  = {op_a, op_b[LABEL_W-1:ADJ_SEL_W]};
        adj_wdata  = adj_rd_reg | (ADJ_BITS'(1) << op_b[ADJ_SEL_W-1:0]);
        unique case (state_reg)
            ST_CLEAR: begin
                stat_we    = 1'b1;
                stat_waddr = clr_reg[LABEL_W-1:0];
                stat_wdata = '0;
                adj_we     = 1'b1;
                adj_waddr  = clr_reg;
                adj_wdata  = '0;
            end
            ST_IDLE: begin
                stat_re = acc;
                line_re = acc;
            end
            ST_PIX_UPD: begin
                stat_we = 1'b1;
                line_we = 1'b1;
            end
            ST_ADJ_RD: adj_re = 1'b1;
            ST_ADJ_WR: adj_we = 1'b1;
            ST_Q_RDW: begin
                adj_re    = 1'b1;
                adj_raddr = {lab_reg, scan_reg[LABEL_W-1:ADJ_SEL_W]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stat_we) stat_mem[stat_waddr] <= stat_wdata;
        if (stat_re) stat_rd_reg <= stat_mem[stat_raddr];
        if (line_we) line_mem[x_reg] <= lab_reg;
        if (line_re) line_rd_reg <= line_mem[x_reg];
        if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
        if (adj_re) adj_rd_reg <= adj_mem[adj_raddr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:   if (clr_reg == '1) state_next = ST_IDLE;
            ST_IDLE: begin
                if (acc) begin
                    unique case (rsa_action_t'(s_tuser))
                        ACT_PIXEL: state_next = ST_PIX_UPD;
                        ACT_QUERY: state_next = ST_Q_STAT;
                        ACT_CLEAR: state_next = ST_CLEAR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PIX_UPD: state_next = (hv || vv) ? ST_ADJ_RD : ST_IDLE;
            ST_ADJ_RD:  state_next = ST_ADJ_WR;
            ST_ADJ_WR: begin
                state_next = ((op_mask_reg & ~(4'b0001 << op_idx)) != '0) ? ST_ADJ_RD : ST_IDLE;
            end
            ST_Q_STAT:  state_next = ST_Q_DIV;
            ST_Q_DIV: begin
                if (div_step_reg == '1 && div_sel_reg == 2'd2) state_next = ST_Q_RDW;
            end
            ST_Q_RDW:   state_next = ST_Q_SCAN;
            ST_Q_SCAN: begin
                priority if (scan_end) state_next = ST_Q_FIN;
                else if (hit && pend_vld_reg && !slot_free) state_next = ST_Q_SCAN;
                else if (scan_reg[ADJ_SEL_W-1:0] == '1) state_next = ST_Q_RDW;
                else state_next = ST_Q_SCAN;
            end
            ST_Q_FIN:   if (slot_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            rcount_reg <= RCNT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (rsa_reg_t'(cfg_index))
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_RCOUNT: rcount_reg <= cfg_data[RCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // control and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg        <= '0;
            y_reg        <= '0;
            left_reg     <= '0;
            clr_reg      <= '0;
            op_mask_reg  <= '0;
            pend_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_tvalid_reg <= 1'b1;
                m_tuser_reg  <= emit_nv;
                m_tlast_reg  <= emit_last;
                m_tdata_reg  <= {1'b0, emit_id,
                                 cnt_nz ? stat_rd_reg.max_y : COORD_W'(0),
                                 cnt_nz ? {1'b0, stat_rd_reg.min_y} : height_reg,
                                 cnt_nz ? stat_rd_reg.max_x : COORD_W'(0),
                                 cnt_nz ? {1'b0, stat_rd_reg.min_x} : width_reg,
                                 mean_reg[2], mean_reg[1], mean_reg[0],
                                 stat_rd_reg.count, lab_reg};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg  <= clr_reg + ADJ_AW'(1);
                    x_reg    <= '0;
                    y_reg    <= '0;
                    left_reg <= '0;
                end
                ST_IDLE: begin
                    clr_reg <= '0;
                    if (acc) begin
                        lab_reg   <= s_tdata[LABEL_W-1:0];
                        red_reg   <= s_tdata[LABEL_W +: 8];
                        green_reg <= s_tdata[LABEL_W+8 +: 8];
                        blue_reg  <= s_tdata[LABEL_W+16 +: 8];
                    end
                end
                ST_PIX_UPD: begin
                    left_save_reg <= left_reg;
                    above_reg     <= line_rd_reg;
                    op_mask_reg   <= {vv, vv, hv, hv};
                    left_reg      <= lab_reg;
                    if (x1 >= w_eff) begin
                        x_reg <= '0;
                        y_reg <= (y1 >= h_eff) ? COORD_W'(0) : y1[COORD_W-1:0];
                    end else begin
                        x_reg <= x1[COORD_W-1:0];
                    end
                end
                ST_ADJ_WR: op_mask_reg <= op_mask_reg & ~(4'b0001 << op_idx);
                ST_Q_STAT: begin
                    div_sel_reg  <= 2'd0;
                    div_step_reg <= '0;
                    rem_reg      <= '0;
                    quo_reg      <= '0;
                    dvd_reg      <= stat_rd_reg.rsum;
                    scan_reg     <= '0;
                    found_reg    <= '0;
                    pend_vld_reg <= 1'b0;
                end
                ST_Q_DIV: begin
                    if (div_step_reg == '1) begin
                        mean_reg[div_sel_reg] <= cnt_nz ? mean_fin : 8'd0;
                        div_sel_reg <= div_sel_reg + 2'd1;
                        rem_reg     <= '0;
                        quo_reg     <= '0;
                        dvd_reg     <= (div_sel_reg == 2'd0) ? stat_rd_reg.gsum
                                                             : stat_rd_reg.bsum;
                    end else begin
                        rem_reg <= ge ? CNT_W'(rem_s - {1'b0, stat_rd_reg.count})
                                      : rem_s[CNT_W-1:0];
                        quo_reg <= quo_fin;
                        dvd_reg <= {dvd_reg[SUM_W-2:0], 1'b0};
                    end
                    div_step_reg <= div_step_reg + 5'd1;
                end
                ST_Q_SCAN: begin
                    if (!scan_end && !(hit && pend_vld_reg && !slot_free)) begin
                        if (hit) begin
                            pend_reg     <= scan_reg[LABEL_W-1:0];
                            pend_vld_reg <= 1'b1;
                            found_reg    <= found_reg + NB_W'(1);
                        end
                        scan_reg <= scan_reg + RCNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign cnt_nz = (stat_rd_reg.count != '0);

endmodule

### sv/rsa_checker.sv
// ----------------------------------------------------------------------------
// rsa_checker
// Port-level checks of the region stats adjacency unit, bound to the top.
// ----------------------------------------------------------------------------
`include "region_stats_adjacency_unit_macros.svh"

module rsa_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic         m_tlast,
    input logic         m_tuser,
    input logic [119:0] m_tdata
);
    `RSA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `RSA_ASSERT_NOW(a_mid_has_nb, aclk, aresetn, m_tvalid && !m_tlast, m_tuser)
    `RSA_ASSERT_NOW(a_no_nb_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[118:109] == 10'd0)
    `RSA_ASSERT_NOW(a_busy_in_query, aclk, aresetn, m_tvalid && !m_tlast, !s_tready)
endmodule

bind region_stats_adjacency_unit rsa_checker u_rsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);
